### rtl/core/all_simple_paths_dfs_macros.svh
// Assertion macros shared by the RTL.
`ifndef ALL_SIMPLE_PATHS_DFS_MACROS_SVH
`define ALL_SIMPLE_PATHS_DFS_MACROS_SVH
`define ASPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/core/aspd_pkg.sv
`default_nettype none
package aspd_pkg;
    localparam int NODES_DEF = 16;
    localparam int SLOTS = 16;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_START = 2'd2,
        OP_NEXT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_ACK  = 2'd0,
        ST_NODE = 2'd1,
        ST_DONE = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] from_node;
        logic [3:0] to_node;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] path_node;
        logic       last;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_READ,
        S_PUSH,
        S_EMIT,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

### rtl/core/all_simple_paths_dfs.sv
// Channel | Direction | Handshake                 | Word
// in      | input     | i_in_valid / o_in_ready   | t_in_word
// out     | output    | o_out_valid / i_out_ready | t_out_word
// Clear, add and start each return one result word.
// Next path takes one sequencer step per stack move: each step pops, skips a
// visited child or pushes one, with a registered read of the neighbor memory,
// then emits one path node per cycle while the output is not stalled.
// Reset clears counts and search state at once; the neighbor memory needs none.
// A stalled output holds the sequencer; the input is not ready while busy.
`default_nettype none
`include "all_simple_paths_dfs_macros.svh"
module all_simple_paths_dfs
    import aspd_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_data
);
    t_state r_state, n_state;
    logic [4:0]  r_cnt [SLOTS];
    logic [3:0]  r_table [SLOTS*SLOTS];
    logic [3:0]  r_path [SLOTS];
    logic [4:0]  r_nidx [SLOTS];
    logic [15:0] r_visit;
    logic [4:0]  r_depth;
    logic        r_active;
    logic [3:0]  r_goal;
    logic [3:0]  r_child;
    logic [3:0]  r_emit;
    t_out_word   r_out;
    logic        r_ovalid;

    logic [3:0] w_d;
    logic [3:0] w_top;
    logic [4:0] w_idx;
    logic       a_ok, b_ok;
    logic       w_add_full;
    logic       w_set_valid;

    assign w_d   = 4'(r_depth - 5'd1);
    assign w_top = r_path[w_d];
    assign w_idx = r_nidx[w_d];
    assign a_ok  = 32'(i_in_data.from_node) < NODES;
    assign b_ok  = 32'(i_in_data.to_node) < NODES;

    // An add word is refused when a node is out of range or its list is full.
    assign w_add_full = (i_in_data.operation == OP_ADD) &&
                        !(a_ok && b_ok && r_cnt[i_in_data.from_node] < 5'(SLOTS));

    assign w_set_valid = (r_state == S_EMIT && (!r_ovalid || i_out_ready)) ||
                         (r_state == S_OUT && r_out.status != ST_NODE);

    assign o_in_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid && o_in_ready) begin
                n_state = (i_in_data.operation == OP_NEXT) ? S_STEP : S_OUT;
            end
            S_STEP: begin
                if (!r_active || r_depth == 5'd0) begin
                    n_state = S_OUT;
                end else if (w_top == r_goal) begin
                    n_state = (w_idx == 5'd0) ? S_EMIT : S_STEP;
                end else if (w_idx >= r_cnt[w_top]) begin
                    n_state = S_STEP;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_PUSH;
            S_PUSH: n_state = S_STEP;
            S_EMIT: if (!r_ovalid || i_out_ready) begin
                n_state = (r_emit == w_d) ? S_OUT : S_EMIT;
            end
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Neighbor memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid && o_in_ready &&
            i_in_data.operation == OP_ADD && a_ok && b_ok &&
            r_cnt[i_in_data.from_node] < 5'(SLOTS)) begin
            r_table[{i_in_data.from_node, r_cnt[i_in_data.from_node][3:0]}] <=
                i_in_data.to_node;
        end
        if (r_state == S_STEP) begin
            r_child <= r_table[{w_top, w_idx[3:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_visit  <= '0;
            r_depth  <= '0;
            r_active <= 1'b0;
            r_goal   <= '0;
            r_ovalid <= 1'b0;
            r_emit   <= '0;
            for (int i = 0; i < SLOTS; i++) r_cnt[i] <= '0;
        end else begin
            r_state <= n_state;
            if (w_set_valid) r_ovalid <= 1'b1;
            else if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid && o_in_ready) begin
                    r_out <= '{status: w_add_full ? ST_FULL : ST_ACK,
                               path_node: 4'd0, last: 1'b1};
                    r_emit <= '0;
                    unique case (t_op'(i_in_data.operation))
                        OP_CLEAR: begin
                            for (int i = 0; i < SLOTS; i++) r_cnt[i] <= '0;
                            r_visit <= '0; r_depth <= '0; r_active <= 1'b0;
                        end
                        OP_ADD: begin
                            if (!w_add_full)
                                r_cnt[i_in_data.from_node] <=
                                    r_cnt[i_in_data.from_node] + 5'd1;
                        end
                        OP_START: begin
                            r_goal <= i_in_data.to_node;
                            if (a_ok && b_ok) begin
                                r_path[0] <= i_in_data.from_node;
                                r_nidx[0] <= '0;
                                r_visit   <= 16'(1) << i_in_data.from_node;
                                r_depth   <= 5'd1;
                                r_active  <= 1'b1;
                            end else begin
                                r_visit  <= '0;
                                r_depth  <= '0;
                                r_active <= 1'b0;
                            end
                        end
                        OP_NEXT: ;
                        default: ;
                    endcase
                end
                S_STEP: begin
                    if (!r_active || r_depth == 5'd0) begin
                        r_visit <= '0; r_depth <= '0; r_active <= 1'b0;
                        r_out <= '{status: ST_DONE, path_node: 4'd0, last: 1'b1};
                    end else if (w_top == r_goal) begin
                        if (w_idx == 5'd0) begin
                            r_nidx[w_d] <= 5'd1;
                        end else begin
                            r_visit[w_top] <= 1'b0;
                            r_depth <= r_depth - 5'd1;
                        end
                    end else if (w_idx >= r_cnt[w_top]) begin
                        r_visit[w_top] <= 1'b0;
                        r_depth <= r_depth - 5'd1;
                    end else begin
                        r_nidx[w_d] <= w_idx + 5'd1;
                    end
                end
                S_READ: ;
                S_PUSH: begin
                    if (!r_visit[r_child] && r_depth < 5'(SLOTS)) begin
                        r_path[r_depth[3:0]] <= r_child;
                        r_nidx[r_depth[3:0]] <= '0;
                        r_visit[r_child] <= 1'b1;
                        r_depth <= r_depth + 5'd1;
                    end
                end
                S_EMIT: if (!r_ovalid || i_out_ready) begin
                    r_out <= '{status: ST_NODE, path_node: r_path[r_emit],
                               last: (r_emit == w_d)};
                    r_emit <= r_emit + 4'd1;
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    `ASPD_ASSERT_IMPL(a_no_ready_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_in_ready)
    `ASPD_ASSERT_IMPL(a_depth_range, i_clk, i_rst_n, 1'b1, r_depth <= 5'(SLOTS))
    `ASPD_ASSERT_IMPL(a_inactive_empty, i_clk, i_rst_n, !r_active && r_state == S_IDLE,
        r_depth == 5'd0)
    `ASPD_ASSERT_NEXT(a_emit_node, i_clk, i_rst_n,
        r_state == S_EMIT && (!r_ovalid || i_out_ready),
        o_out_valid && o_out_data.status == ST_NODE)
endmodule
`default_nettype wire
